// ----- rtl/pngp_pkg.sv -----
// ----------------------------------------------------------------------------
// pngp_pkg: shared types and constants for the PNG chunk stream parser
// Phase, result kind and status codes, the signature table, the byte-wide
// CRC-32 step and the image header check.
// ----------------------------------------------------------------------------
package pngp_pkg;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5,
        PH_ERR  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CHUNK   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SIGNATURE = 4'd1,
        ST_CRC       = 4'd2,
        ST_SHORT     = 4'd3,
        ST_ZERO_SIZE = 4'd4,
        ST_DEPTH     = 4'd5,
        ST_COLOR     = 4'd6,
        ST_PAIR      = 4'd7,
        ST_COMPRESS  = 4'd8,
        ST_FILTER    = 4'd9,
        ST_INTERLACE = 4'd10
    } t_status;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        t_status     status;
        logic        is_last_chunk;
        logic [31:0] img_width;
        logic [31:0] img_height;
        logic [7:0]  bit_depth;
        logic [7:0]  color_type;
        logic        interlaced;
    } t_result;

    localparam int          HdrLen   = 13;
    localparam logic [31:0] TypeIend = 32'h49454E44;
    localparam logic [31:0] CrcPoly  = 32'hEDB88320;

    // PNG file signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] v;
        case (pos)
            3'd0: v = 8'd137;
            3'd1: v = 8'd80;
            3'd2: v = 8'd78;
            3'd3: v = 8'd71;
            3'd4: v = 8'd13;
            3'd5: v = 8'd10;
            3'd6: v = 8'd26;
            default: v = 8'd10;
        endcase
        return v;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    // image header check; the first failing test wins
    function automatic t_status hdr_status(
        input logic        short_hdr,
        input logic [31:0] width,
        input logic [31:0] height,
        input logic [7:0]  depth,
        input logic [7:0]  color,
        input logic [7:0]  compress,
        input logic [7:0]  filter,
        input logic [7:0]  interlace
    );
        logic    depth_any;
        logic    color_any;
        logic    pair_ok;
        t_status st;
        depth_any = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) ||
                    (depth == 8'd8) || (depth == 8'd16);
        color_any = (color == 8'd0) || (color == 8'd2) || (color == 8'd3) ||
                    (color == 8'd4) || (color == 8'd6);
        if ((color == 8'd2) || (color == 8'd4) || (color == 8'd6)) begin
            pair_ok = (depth == 8'd8) || (depth == 8'd16);
        end else if (color == 8'd3) begin
            pair_ok = (depth <= 8'd8);
        end else begin
            pair_ok = 1'b1;
        end
        if (short_hdr) begin
            st = ST_SHORT;
        end else if ((width == 32'd0) || (height == 32'd0)) begin
            st = ST_ZERO_SIZE;
        end else if (!depth_any) begin
            st = ST_DEPTH;
        end else if (!color_any) begin
            st = ST_COLOR;
        end else if (!pair_ok) begin
            st = ST_PAIR;
        end else if (compress != 8'd0) begin
            st = ST_COMPRESS;
        end else if (filter != 8'd0) begin
            st = ST_FILTER;
        end else if (interlace > 8'd1) begin
            st = ST_INTERLACE;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

// ----- rtl/png_chunk_stream_parser.sv -----
// ----------------------------------------------------------------------------
// png_chunk_stream_parser: byte-serial PNG container walker
// Checks the signature, walks the chunks, emits chunk data bytes, checks
// the CRC-32 of every chunk and validates the first chunk as image header.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one file byte per transfer (i_stream_byte), with
//   i_start_of_file high on the first byte of a file to restart parsing.
//   Output channel: at most one result per input byte: a payload byte for
//   every chunk data byte, a chunk-finished record after each good CRC
//   (header fields on the first chunk, last flag on IEND) or one error
//   record, after which bytes are dropped until the next start of file.
//   Latency: a result is valid in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while o_stall is low; the per-byte CRC
//   step, the field counter updates and the header check are combinational.
//   The output register holds a result while i_stall is high; o_stall
//   rises only while that register is full and stalled, so bytes that
//   make no result and bytes after a taken result flow on.
//   Reset: synchronous, active low; the parser waits for a signature and
//   the output register is emptied. Header byte storage is not cleared.
// ----------------------------------------------------------------------------
module png_chunk_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_chunk_type,
    output logic [31:0] o_chunk_length,
    output logic [3:0]  o_status,
    output logic        o_is_last_chunk,
    output logic [31:0] o_img_width,
    output logic [31:0] o_img_height,
    output logic [7:0]  o_bit_depth,
    output logic [7:0]  o_color_type,
    output logic        o_interlaced
);

    // parser state
    pngp_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_pos, n_pos;
    logic [31:0]      r_remain, n_remain;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_type, n_type;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_crc_rx, n_crc_rx;
    logic             r_first, n_first;
    logic [3:0]       r_hidx, n_hidx;
    logic [7:0]       r_hdr [pngp_pkg::HdrLen];
    logic             w_hdr_we;

    // output register
    logic               r_out_valid;
    pngp_pkg::t_result  r_out;
    pngp_pkg::t_result  w_res;
    logic               w_res_valid;

    logic               w_accept;
    pngp_pkg::t_phase   e_phase;
    logic [2:0]         e_pos;
    logic [31:0]        e_len;
    logic [31:0]        e_type;
    logic               e_first;
    logic [31:0]        w_crc_step;
    logic [31:0]        w_crc_full;
    logic               w_crc_bad;
    logic               w_sig_bad;
    pngp_pkg::t_status  w_hdr_st;
    logic               w_last_pos;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // state as seen by this byte: start of file restarts the parser
    assign e_phase = i_start_of_file ? pngp_pkg::PH_SIG : r_phase;
    assign e_pos   = i_start_of_file ? 3'd0 : r_pos;
    assign e_len   = i_start_of_file ? 32'd0 : r_len;
    assign e_type  = i_start_of_file ? 32'd0 : r_type;
    assign e_first = i_start_of_file ? 1'b1 : r_first;

    // shared per-byte terms
    assign w_crc_step = pngp_pkg::crc_byte(r_crc, i_stream_byte);
    assign w_crc_full = {r_crc_rx[23:0], i_stream_byte};
    assign w_crc_bad  = (w_crc_full != ~r_crc);
    assign w_sig_bad  = (i_stream_byte != pngp_pkg::sig_byte(e_pos));
    assign w_last_pos = (e_pos == 3'd3);
    assign w_hdr_st   = pngp_pkg::hdr_status(
        (r_len < 32'(pngp_pkg::HdrLen)),
        {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3]},
        {r_hdr[4], r_hdr[5], r_hdr[6], r_hdr[7]},
        r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11], r_hdr[12]);

    // next state
    always_comb begin
        n_phase  = e_phase;
        n_pos    = e_pos;
        n_remain = r_remain;
        n_len    = e_len;
        n_type   = e_type;
        n_crc    = r_crc;
        n_crc_rx = r_crc_rx;
        n_first  = e_first;
        n_hidx   = r_hidx;
        w_hdr_we = 1'b0;
        case (e_phase)
            pngp_pkg::PH_SIG: begin
                if (w_sig_bad) begin
                    n_phase = pngp_pkg::PH_ERR;
                end else if (e_pos == 3'd7) begin
                    n_pos   = 3'd0;
                    n_len   = 32'd0;
                    n_phase = pngp_pkg::PH_LEN;
                end else begin
                    n_pos = e_pos + 3'd1;
                end
            end
            pngp_pkg::PH_LEN: begin
                if (e_pos == 3'd0) begin
                    n_len  = {24'd0, i_stream_byte};
                    n_type = 32'd0;
                end else begin
                    n_len = {e_len[23:0], i_stream_byte};
                end
                if (w_last_pos) begin
                    n_pos   = 3'd0;
                    n_crc   = '1;
                    n_phase = pngp_pkg::PH_TYPE;
                end else begin
                    n_pos = e_pos + 3'd1;
                end
            end
            pngp_pkg::PH_TYPE: begin
                n_type = {e_type[23:0], i_stream_byte};
                n_crc  = w_crc_step;
                if (w_last_pos) begin
                    n_pos    = 3'd0;
                    n_remain = e_len;
                    n_crc_rx = 32'd0;
                    n_hidx   = 4'd0;
                    n_phase  = (e_len == 32'd0) ? pngp_pkg::PH_CRC : pngp_pkg::PH_DATA;
                end else begin
                    n_pos = e_pos + 3'd1;
                end
            end
            pngp_pkg::PH_DATA: begin
                // capture the first header bytes of the first chunk
                if (r_hidx < 4'(pngp_pkg::HdrLen)) begin
                    w_hdr_we = e_first;
                    n_hidx   = r_hidx + 4'd1;
                end
                n_crc    = w_crc_step;
                n_remain = r_remain - 32'd1;
                if (r_remain == 32'd1) begin
                    n_crc_rx = 32'd0;
                    n_phase  = pngp_pkg::PH_CRC;
                end
            end
            pngp_pkg::PH_CRC: begin
                n_crc_rx = w_crc_full;
                if (w_last_pos) begin
                    n_pos = 3'd0;
                    if (w_crc_bad) begin
                        n_phase = pngp_pkg::PH_ERR;
                    end else if (e_first && (w_hdr_st != pngp_pkg::ST_OK)) begin
                        n_phase = pngp_pkg::PH_ERR;
                    end else begin
                        n_first = 1'b0;
                        n_phase = (e_type == pngp_pkg::TypeIend) ?
                                  pngp_pkg::PH_DONE : pngp_pkg::PH_LEN;
                    end
                end else begin
                    n_pos = e_pos + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // result for this byte
    always_comb begin
        w_res_valid        = 1'b0;
        w_res              = '0;
        w_res.kind         = pngp_pkg::KIND_PAYLOAD;
        w_res.status       = pngp_pkg::ST_OK;
        w_res.chunk_type   = e_type;
        w_res.chunk_length = e_len;
        case (e_phase)
            pngp_pkg::PH_SIG: begin
                if (w_sig_bad) begin
                    w_res_valid  = 1'b1;
                    w_res.kind   = pngp_pkg::KIND_ERROR;
                    w_res.status = pngp_pkg::ST_SIGNATURE;
                end
            end
            pngp_pkg::PH_DATA: begin
                w_res_valid        = 1'b1;
                w_res.payload_byte = i_stream_byte;
            end
            pngp_pkg::PH_CRC: begin
                if (w_last_pos) begin
                    w_res_valid = 1'b1;
                    if (w_crc_bad) begin
                        w_res.kind   = pngp_pkg::KIND_ERROR;
                        w_res.status = pngp_pkg::ST_CRC;
                    end else if (e_first && (w_hdr_st != pngp_pkg::ST_OK)) begin
                        w_res.kind   = pngp_pkg::KIND_ERROR;
                        w_res.status = w_hdr_st;
                    end else begin
                        w_res.kind          = pngp_pkg::KIND_CHUNK;
                        w_res.is_last_chunk = (e_type == pngp_pkg::TypeIend);
                        if (e_first) begin
                            w_res.img_width  = {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3]};
                            w_res.img_height = {r_hdr[4], r_hdr[5], r_hdr[6], r_hdr[7]};
                            w_res.bit_depth  = r_hdr[8];
                            w_res.color_type = r_hdr[9];
                            w_res.interlaced = r_hdr[12][0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pngp_pkg::PH_SIG;
            r_pos   <= 3'd0;
            r_len   <= 32'd0;
            r_type  <= 32'd0;
            r_first <= 1'b1;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_type  <= n_type;
            r_first <= n_first;
        end
    end

    // datapath state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_remain <= n_remain;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
            r_hidx   <= n_hidx;
            if (w_hdr_we) begin
                r_hdr[r_hidx] <= i_stream_byte;
            end
        end
    end

    // output register: load on a new result, drop after a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_chunk_type    = r_out.chunk_type;
    assign o_chunk_length  = r_out.chunk_length;
    assign o_status        = r_out.status;
    assign o_is_last_chunk = r_out.is_last_chunk;
    assign o_img_width     = r_out.img_width;
    assign o_img_height    = r_out.img_height;
    assign o_bit_depth     = r_out.bit_depth;
    assign o_color_type    = r_out.color_type;
    assign o_interlaced    = r_out.interlaced;

    // a data byte always turns into a payload result
    a_data_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_start_of_file && (r_phase == pngp_pkg::PH_DATA))
        |=> (o_valid && (o_kind == pngp_pkg::KIND_PAYLOAD)))
        else $error("data byte did not produce a payload result");

    // an error result parks the parser
    a_error_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_res_valid && (w_res.kind == pngp_pkg::KIND_ERROR))
        |=> (r_phase == pngp_pkg::PH_ERR))
        else $error("parser not parked after error");

    // last flag only on a good chunk record
    a_last_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last_chunk)
        |-> ((o_kind == pngp_pkg::KIND_CHUNK) && (o_status == pngp_pkg::ST_OK)))
        else $error("last chunk flag on a bad record");

    // field byte counter stays within a 4-byte field while walking chunks;
    // a signature error parks with the signature position as it was
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase != pngp_pkg::PH_SIG) && (r_phase != pngp_pkg::PH_ERR))
        |-> (r_pos < 3'd4))
        else $error("field byte counter out of range");

endmodule
